FILE: rtl/core/asne_pkg.sv
// ----------------------------------------------------------------------------
// asne_pkg
// Shared types and constants for the advertising-data name extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package asne_pkg;

    // configuration register indexes
    localparam logic CFG_COMPLETE_NAME = 1'b0;
    localparam logic CFG_SHORT_NAME    = 1'b1;

    localparam logic [7:0] COMPLETE_NAME_RESET = 8'd9;
    localparam logic [7:0] SHORT_NAME_RESET    = 8'd8;

    // widest run length the block can ever hold (capacity at most 256)
    localparam int RUN_LEN_W = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] name_char;
        logic [4:0] char_index;
        logic [4:0] name_length;
        logic       name_found;
        logic       run_end;
    } t_out;

    // parser -> drain: start of an output run
    typedef struct packed {
        logic                 start;
        logic                 found;
        logic [1:0]           bank;
        logic [RUN_LEN_W-1:0] len;
    } t_run;

    // drain -> parser: bank still being read out
    typedef struct packed {
        logic       busy;
        logic [1:0] bank;
    } t_lock;

    // first of the three name banks that is neither committed nor locked
    function automatic logic [1:0] free_bank(input logic [1:0] committed,
                                             input logic [1:0] locked);
        logic [1:0] pick;
        pick = 2'd2;
        if (committed != 2'd0 && locked != 2'd0) begin
            pick = 2'd0;
        end else if (committed != 2'd1 && locked != 2'd1) begin
            pick = 2'd1;
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/asne_ram.sv
// ----------------------------------------------------------------------------
// asne_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/asne_parser.sv
// ----------------------------------------------------------------------------
// asne_parser
// Length-type-value walker: tracks the structure, writes name bytes into a
// free bank and commits the bank when a non-empty name structure completes.
// ----------------------------------------------------------------------------
`default_nettype none

module asne_parser #(
    parameter int NAME_CAPACITY = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [7:0]                          i_cfg_data,
    input  wire logic                                i_accept,
    input  wire asne_pkg::t_in                       i_item,
    input  wire asne_pkg::t_lock                     i_lock,
    output logic                                     o_we,
    output logic [$clog2(NAME_CAPACITY)+1:0]         o_waddr,
    output logic [7:0]                               o_wdata,
    output asne_pkg::t_run                           o_run
);

    localparam int LEN_W = $clog2(NAME_CAPACITY);
    localparam logic [LEN_W-1:0] SLOTS = LEN_W'(NAME_CAPACITY - 1);

    typedef enum logic [3:0] {
        PH_LENGTH  = 4'b0001,
        PH_TYPE    = 4'b0010,
        PH_VALUE   = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_remaining, n_remaining;
    logic             r_is_name, n_is_name;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [LEN_W-1:0] r_clen, n_clen;
    logic [1:0]       r_pbank, n_pbank;
    logic [1:0]       r_cbank, n_cbank;
    logic [7:0]       r_complete_type, r_short_type;

    logic [7:0]       rem_dec;
    logic [1:0]       lock_bank;
    logic             wr;

    assign rem_dec   = r_remaining - 8'd1;
    assign lock_bank = i_lock.busy ? i_lock.bank : r_cbank;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_is_name   = r_is_name;
        n_plen      = r_plen;
        n_clen      = r_clen;
        n_pbank     = r_pbank;
        n_cbank     = r_cbank;
        wr          = 1'b0;

        unique case (r_phase)
            PH_LENGTH: begin
                if (i_item.data_byte == 8'd0) begin
                    n_phase = PH_STOPPED;
                end else begin
                    n_remaining = i_item.data_byte;
                    n_phase     = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_is_name   = (i_item.data_byte == r_complete_type) ||
                              (i_item.data_byte == r_short_type);
                n_plen      = '0;
                n_pbank     = asne_pkg::free_bank(r_cbank, lock_bank);
                n_remaining = rem_dec;
                n_phase     = (rem_dec == 8'd0) ? PH_LENGTH : PH_VALUE;
            end
            PH_VALUE: begin
                if (r_is_name && r_plen < SLOTS) begin
                    wr     = 1'b1;
                    n_plen = r_plen + 1'b1;
                end
                n_remaining = rem_dec;
                if (rem_dec == 8'd0) begin
                    if (r_is_name && n_plen != '0) begin
                        n_clen  = n_plen;
                        n_cbank = r_pbank;
                    end
                    n_phase = PH_LENGTH;
                end
            end
            PH_STOPPED: begin
            end
            default: begin
                n_phase = PH_LENGTH;
            end
        endcase

        o_run.start = i_accept && i_item.last_byte;
        o_run.found = n_clen != '0;
        o_run.bank  = n_cbank;
        o_run.len   = asne_pkg::RUN_LEN_W'(n_clen);

        // payload state clears once the run is handed over
        if (i_item.last_byte) begin
            n_phase     = PH_LENGTH;
            n_remaining = 8'd0;
            n_is_name   = 1'b0;
            n_plen      = '0;
            n_clen      = '0;
        end
    end

    assign o_we    = i_accept && wr;
    assign o_waddr = {r_pbank, r_plen};
    assign o_wdata = i_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LENGTH;
            r_remaining     <= 8'd0;
            r_is_name       <= 1'b0;
            r_plen          <= '0;
            r_clen          <= '0;
            r_pbank         <= 2'd1;
            r_cbank         <= 2'd0;
            r_complete_type <= asne_pkg::COMPLETE_NAME_RESET;
            r_short_type    <= asne_pkg::SHORT_NAME_RESET;
        end else begin
            if (i_accept) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_is_name   <= n_is_name;
                r_plen      <= n_plen;
                r_clen      <= n_clen;
                r_pbank     <= n_pbank;
                r_cbank     <= n_cbank;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    asne_pkg::CFG_COMPLETE_NAME: r_complete_type <= i_cfg_data;
                    asne_pkg::CFG_SHORT_NAME:    r_short_type    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/asne_drain.sv
// ----------------------------------------------------------------------------
// asne_drain
// Reads a committed name out of its bank, one character a cycle while the
// output buffer has room, into a two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module asne_drain #(
    parameter int NAME_CAPACITY = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire asne_pkg::t_run              i_run,
    output asne_pkg::t_lock                  o_lock,
    output logic                             o_re,
    output logic [$clog2(NAME_CAPACITY)+1:0] o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output asne_pkg::t_out                   o_out
);

    localparam int LEN_W = $clog2(NAME_CAPACITY);

    logic             r_active;
    logic [LEN_W-1:0] r_k, r_len;
    logic [1:0]       r_bank;
    logic             r_found;

    // read in flight
    logic             r_rd_vld;
    logic [LEN_W-1:0] r_rd_k, r_rd_len;
    logic             r_rd_found, r_rd_end;

    logic             r_out_vld, r_skid_vld;
    asne_pkg::t_out   r_out, r_skid;

    logic [1:0]       occ;
    logic             pop, issue, last_rd;
    asne_pkg::t_out   arr;

    assign pop     = r_out_vld && i_out_ready;
    assign occ     = {1'b0, r_out_vld} + {1'b0, r_skid_vld} + {1'b0, r_rd_vld};
    assign issue   = r_active && ((occ - {1'b0, pop}) < 2'd2);
    assign last_rd = !r_found || (r_k + 1'b1 == r_len);

    assign arr.name_char   = r_rd_found ? i_rdata : 8'd0;
    assign arr.char_index  = 5'(r_rd_k);
    assign arr.name_length = 5'(r_rd_len);
    assign arr.name_found  = r_rd_found;
    assign arr.run_end     = r_rd_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_run.start) begin
                r_active <= 1'b1;
                r_k      <= '0;
                r_len    <= i_run.len[LEN_W-1:0];
                r_bank   <= i_run.bank;
                r_found  <= i_run.found;
            end else if (issue) begin
                r_k <= r_k + 1'b1;
                if (last_rd) begin
                    r_active <= 1'b0;
                end
            end

            r_rd_vld <= issue;
            if (issue) begin
                r_rd_k     <= r_found ? r_k : '0;
                r_rd_len   <= r_len;
                r_rd_found <= r_found;
                r_rd_end   <= last_rd;
            end

            if (!r_out_vld || pop) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= r_rd_vld;
                    r_skid     <= arr;
                end else begin
                    r_out     <= arr;
                    r_out_vld <= r_rd_vld;
                end
            end else if (r_rd_vld) begin
                r_skid     <= arr;
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_lock.busy = r_active;
    assign o_lock.bank = r_bank;
    assign o_re        = issue;
    assign o_raddr     = {r_bank, r_k};
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/ad_structure_name_extractor.sv
// output: a result run starts after its last payload byte is
// accepted and then gives one character per cycle while the output is taken
// throughput: one payload byte per cycle; a last byte waits only while the
// previous run is still being read out of the name buffer's single read port
// reset: synchronous, active low; clears parse and output control, restores
// the name types to 9 and 8; the name buffer needs no clearing
// ----------------------------------------------------------------------------
// ad_structure_name_extractor
// Advertising payload parser that returns the last committed local name.
// ----------------------------------------------------------------------------
`default_nettype none

module ad_structure_name_extractor #(
    parameter int NAME_CAPACITY = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [7:0]     i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire asne_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output asne_pkg::t_out      o_out
);

    localparam int LEN_W = $clog2(NAME_CAPACITY);
    localparam int DEPTH = 3 * (2 ** LEN_W);

    logic             accept;
    asne_pkg::t_run   run;
    asne_pkg::t_lock  lock;
    logic             we, re;
    logic [LEN_W+1:0] waddr, raddr;
    logic [7:0]       wdata, rdata;

    // a last byte needs the read-out side free to start its run
    assign o_in_ready = !(lock.busy && i_in.last_byte);
    assign accept     = i_in_valid && o_in_ready;

    asne_parser #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in),
        .i_lock      (lock),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_run       (run)
    );

    asne_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    asne_drain #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run),
        .o_lock      (lock),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/core/asne_checker.sv
// ----------------------------------------------------------------------------
// asne_checker
// Port-level checks on the result runs of the name extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module asne_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire asne_pkg::t_out o_out
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // not-found result is a lone all-zero item
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.name_found |->
            o_out.run_end && o_out.name_length == 5'd0 &&
            o_out.char_index == 5'd0 && o_out.name_char == 8'd0)
        else $error("malformed not-found result");

    // characters of a run come in order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.run_end |=>
            !o_out_valid || o_out.char_index == 5'($past(o_out.char_index) + 5'd1))
        else $error("character index skipped");

    // one length for the whole run
    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.run_end |=>
            !o_out_valid || o_out.name_length == $past(o_out.name_length))
        else $error("name length changed within a run");

    // run ends on the final character
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.name_found && o_out.run_end &&
            o_out.name_length != 5'd0 |->
            o_out.char_index == o_out.name_length - 5'd1)
        else $error("run ended on the wrong character");

endmodule

bind ad_structure_name_extractor asne_checker u_asne_checker (.*);

`default_nettype wire

FILE: tb/tb_ad_structure_name_extractor.sv
// ----------------------------------------------------------------------------
// tb_ad_structure_name_extractor
// Self-checking bench for the advertising payload name extractor: a short
// table of hand-built payloads, then random payloads (mostly well-formed
// length-type-value chains, some cut off, some plain noise) under changing
// name type codes. Each name character is checked against a behavioral
// parser kept in step with every accepted payload byte.
// ----------------------------------------------------------------------------
module tb_ad_structure_name_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_CAPACITY = 32;
    localparam int NAME_SLOTS    = NAME_CAPACITY - 1;
    localparam int RANDOM_BYTES  = 300;

    localparam asne_pkg::t_out NO_NAME = '{name_char: 8'h00, char_index: 5'd0,
                                           name_length: 5'd0, name_found: 1'b0,
                                           run_end: 1'b1};

    typedef enum logic [3:0] {
        WANT_LENGTH = 4'b0001,
        WANT_TYPE   = 4'b0010,
        IN_VALUE    = 4'b0100,
        HALTED      = 4'b1000
    } t_parse_phase;

    typedef struct {
        logic          cfg_before;
        logic          cfg_index;
        logic [7:0]    cfg_value;
        asne_pkg::t_in item;
        logic          no_name;
    } t_payload_row;

    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_cfg_we    = 1'b0;
    logic           i_cfg_index = asne_pkg::CFG_COMPLETE_NAME;
    logic [7:0]     i_cfg_data  = 8'h00;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    asne_pkg::t_in  i_in        = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    asne_pkg::t_out o_out;

    // behavioral parser state
    logic [7:0]   cur_complete_type = asne_pkg::COMPLETE_NAME_RESET;
    logic [7:0]   cur_short_type    = asne_pkg::SHORT_NAME_RESET;
    t_parse_phase ps_phase          = WANT_LENGTH;
    logic [7:0]   ps_remaining      = 8'h00;
    logic         ps_is_name        = 1'b0;
    logic [7:0]   ps_pending [NAME_SLOTS];
    int           ps_pending_len    = 0;
    logic [7:0]   ps_name [NAME_SLOTS];
    int           ps_name_len       = 0;

    asne_pkg::t_out name_chars_q [$];
    logic [7:0]     payload_q [$];
    t_payload_row   directed_rows [$];

    logic steady         = 1'b0;
    int   failures       = 0;
    int   bytes_sent     = 0;
    int   payloads_sent  = 0;
    int   chars_taken    = 0;
    int   runs_taken     = 0;
    int   settings_used  = 0;

    ad_structure_name_extractor #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("ad_structure_name_extractor regression: fail");
        $finish;
    end

    // advance the parser by one byte; on the last byte queue the name run
    task automatic parse_byte(input asne_pkg::t_in item);
        int             k;
        asne_pkg::t_out ch;
        case (ps_phase)
            WANT_LENGTH: begin
                if (item.data_byte == 8'h00) begin
                    ps_phase = HALTED;
                end else begin
                    ps_remaining = item.data_byte;
                    ps_phase     = WANT_TYPE;
                end
            end
            WANT_TYPE: begin
                ps_is_name     = (item.data_byte == cur_complete_type) ||
                                 (item.data_byte == cur_short_type);
                ps_pending_len = 0;
                ps_remaining   = ps_remaining - 8'd1;
                ps_phase       = (ps_remaining == 8'd0) ? WANT_LENGTH : IN_VALUE;
            end
            IN_VALUE: begin
                if (ps_is_name && ps_pending_len < NAME_SLOTS) begin
                    ps_pending[ps_pending_len] = item.data_byte;
                    ps_pending_len++;
                end
                ps_remaining = ps_remaining - 8'd1;
                if (ps_remaining == 8'd0) begin
                    // name replaces the stored one only once the structure completes
                    if (ps_is_name && ps_pending_len > 0) begin
                        for (k = 0; k < ps_pending_len; k++) ps_name[k] = ps_pending[k];
                        ps_name_len = ps_pending_len;
                    end
                    ps_phase = WANT_LENGTH;
                end
            end
            default: begin
            end
        endcase
        if (item.last_byte) begin
            if (ps_name_len == 0) begin
                name_chars_q = {name_chars_q, NO_NAME};
            end else begin
                for (k = 0; k < ps_name_len; k++) begin
                    ch.name_char   = ps_name[k];
                    ch.char_index  = k[4:0];
                    ch.name_length = ps_name_len[4:0];
                    ch.name_found  = 1'b1;
                    ch.run_end     = (k == ps_name_len - 1);
                    name_chars_q   = {name_chars_q, ch};
                end
            end
            ps_phase       = WANT_LENGTH;
            ps_remaining   = 8'h00;
            ps_is_name     = 1'b0;
            ps_pending_len = 0;
            ps_name_len    = 0;
        end
    endtask

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_byte(input asne_pkg::t_in item, input logic no_name);
        int queued;
        while (!steady && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        queued = name_chars_q.size();
        parse_byte(item);
        if (no_name) begin
            while (name_chars_q.size() > queued) void'(name_chars_q.pop_back());
            name_chars_q = {name_chars_q, NO_NAME};
        end
        bytes_sent++;
        if (item.last_byte) payloads_sent++;
    endtask

    // let every expected character drain and the parser go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (name_chars_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == asne_pkg::CFG_COMPLETE_NAME) cur_complete_type = val;
        else cur_short_type = val;
    endtask

    function automatic t_payload_row row(input logic [7:0] b, input logic last,
                                         input logic no_name);
        t_payload_row r;
        r.cfg_before     = 1'b0;
        r.cfg_index      = asne_pkg::CFG_COMPLETE_NAME;
        r.cfg_value      = 8'h00;
        r.item.data_byte = b;
        r.item.last_byte = last;
        r.no_name        = no_name;
        return r;
    endfunction

    function automatic logic [7:0] value_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void build_payload();
        int         kind;
        int         fields;
        int         vlen;
        int         r;
        int         n;
        logic [7:0] ty;
        payload_q.delete();
        kind = $urandom_range(99);
        if (kind >= 88) begin
            n = $urandom_range(1, 10);
            repeat (n) payload_q = {payload_q, 8'($urandom)};
            return;
        end
        fields = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(0, 2);
        repeat (fields) begin
            r = $urandom_range(99);
            if (r < 10) vlen = 0;
            else if (r < 22) vlen = $urandom_range(NAME_SLOTS, NAME_SLOTS + 9);
            else vlen = $urandom_range(1, 8);
            r  = $urandom_range(99);
            ty = (r < 40) ? cur_complete_type : (r < 75) ? cur_short_type : 8'($urandom);
            payload_q = {payload_q, 8'(vlen + 1)};
            payload_q = {payload_q, ty};
            repeat (vlen) payload_q = {payload_q, value_byte()};
        end
        if (kind < 70) begin
            if ($urandom_range(99) < 25) begin
                payload_q = {payload_q, 8'h00};
                n = $urandom_range(0, 3);
                repeat (n) payload_q = {payload_q, 8'($urandom)};
            end
        end else begin
            // structure header promising more bytes than the payload still holds
            n = $urandom_range(0, 6);
            payload_q = {payload_q, (($urandom_range(3) == 0) ? 8'hFF :
                                     8'($urandom_range(n + 2, 200)))};
            payload_q = {payload_q, ($urandom_range(1) ? cur_complete_type :
                                     cur_short_type)};
            repeat (n) payload_q = {payload_q, value_byte()};
        end
    endfunction

    task automatic check_char(input asne_pkg::t_out want, input asne_pkg::t_out got);
        if (got.name_char !== want.name_char) begin
            $error("name_char: expected %0h, got %0h", want.name_char, got.name_char);
            failures++;
        end
        if (got.char_index !== want.char_index) begin
            $error("char_index: expected %0d, got %0d", want.char_index, got.char_index);
            failures++;
        end
        if (got.name_length !== want.name_length) begin
            $error("name_length: expected %0d, got %0d", want.name_length, got.name_length);
            failures++;
        end
        if (got.name_found !== want.name_found) begin
            $error("name_found: expected %0b, got %0b", want.name_found, got.name_found);
            failures++;
        end
        if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (name_chars_q.size() == 0) begin
                $error("name character with nothing expected: char %0h index %0d",
                       o_out.name_char, o_out.char_index);
                failures++;
            end else begin
                check_char(name_chars_q.pop_front(), o_out);
            end
            chars_taken++;
            if (o_out.run_end) runs_taken++;
        end
    end

    initial begin : stimulus
        t_payload_row  dr;
        asne_pkg::t_in item;
        int            p;
        int            w;
        int            rand_base;
        logic [7:0]    c_type;
        logic [7:0]    s_type;

        // zero length right away: nothing found
        directed_rows = {directed_rows, row(8'h00, 1'b1, 1'b1)};
        // complete name "AB"
        directed_rows = {directed_rows, row(8'h03, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(asne_pkg::COMPLETE_NAME_RESET, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h41, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h42, 1'b1, 1'b0)};
        // short name holding a zero byte, then a stop and an ignored byte
        directed_rows = {directed_rows, row(8'h04, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(asne_pkg::SHORT_NAME_RESET, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h00, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'hFF, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h7F, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h00, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'hFF, 1'b1, 1'b0)};
        // type-only name structure, then a name cut off by the payload end
        directed_rows = {directed_rows, row(8'h01, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(asne_pkg::COMPLETE_NAME_RESET, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h05, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(asne_pkg::COMPLETE_NAME_RESET, 1'b0, 1'b0)};
        directed_rows = {directed_rows, row(8'h41, 1'b1, 1'b1)};
        // name type changed between the length byte and the type byte
        directed_rows = {directed_rows, row(8'h02, 1'b0, 1'b0)};
        dr            = row(8'hFF, 1'b0, 1'b0);
        dr.cfg_before = 1'b1;
        dr.cfg_index  = asne_pkg::CFG_COMPLETE_NAME;
        dr.cfg_value  = 8'hFF;
        directed_rows = {directed_rows, dr};
        directed_rows = {directed_rows, row(8'h5A, 1'b1, 1'b0)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            dr = directed_rows[i];
            if (dr.cfg_before) begin
                settle();
                write_reg(dr.cfg_index, dr.cfg_value);
            end
            send_byte(dr.item, dr.no_name);
        end

        p         = 0;
        rand_base = bytes_sent;
        while (bytes_sent - rand_base < RANDOM_BYTES) begin
            if (p % 4 == 0) begin
                settle();
                case ((p / 4) % 6)
                    0: begin c_type = 8'h00; s_type = 8'hFF; end
                    1: begin c_type = 8'hFF; s_type = 8'h00; end
                    2: begin c_type = 8'h41; s_type = 8'h41; end
                    3: begin
                        c_type = asne_pkg::COMPLETE_NAME_RESET;
                        s_type = asne_pkg::SHORT_NAME_RESET;
                    end
                    default: begin c_type = 8'($urandom); s_type = 8'($urandom); end
                endcase
                write_reg(asne_pkg::CFG_COMPLETE_NAME, c_type);
                write_reg(asne_pkg::CFG_SHORT_NAME, s_type);
                settings_used++;
            end
            // a run of payloads with no idling on either side
            steady = (p >= 8 && p < 13);
            build_payload();
            foreach (payload_q[j]) begin
                item.data_byte = payload_q[j];
                item.last_byte = (j == payload_q.size() - 1);
                send_byte(item, 1'b0);
            end
            p++;
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        for (w = 0; w < 20000 && name_chars_q.size() != 0; w++) @(posedge i_clk);
        if (name_chars_q.size() != 0) begin
            $error("%0d expected name characters never arrived", name_chars_q.size());
            failures++;
        end
        repeat (10) @(posedge i_clk);

        $display("sent %0d payload bytes in %0d payloads over %0d name type settings",
                 bytes_sent, payloads_sent, settings_used + 2);
        $display("checked %0d name characters in %0d runs", chars_taken, runs_taken);
        if (failures == 0) begin
            $display("ad_structure_name_extractor regression: pass");
        end else begin
            $display("ad_structure_name_extractor regression: fail");
        end
        $finish;
    end

endmodule
